FILE: rtl/core/tqvg_pkg.sv
// shared types and constants of the tile quad vertex generator
`default_nettype none

package tqvg_pkg;

  // field widths
  localparam int TILE_W    = 16;
  localparam int COL_W     = 10;
  localparam int ROW_W     = 10;
  localparam int CORNER_W  = 2;
  localparam int POS_W     = 19;
  localparam int TEX_U_W   = 14;
  localparam int TEX_V_W   = 25;

  // configuration register widths
  localparam int SIDE_W    = 11;
  localparam int TS_W      = 9;
  localparam int ATLAS_W   = 14;
  localparam int PER_ROW_W = 14;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 14;

  // remainder of the tile divider, below tiles per row
  localparam int REM_W     = PER_ROW_W;
  // quotient bits resolved per divider stage
  localparam int DIV_STEPS = 4;
  // iterations of the tiles-per-row divider
  localparam logic [3:0] CFG_DIV_ITERS = 4'd14;

  // corner codes
  localparam logic [CORNER_W-1:0] CORNER_LAST = 2'd3;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MAP_WIDTH   = 4'd0,
    CFG_MAP_HEIGHT  = 4'd1,
    CFG_TILE_SIZE   = 4'd2,
    CFG_ATLAS_WIDTH = 4'd3
  } tqvg_cfg_index_t;

  // settings seen by the item pipeline
  typedef struct packed {
    logic [SIDE_W-1:0]    map_width;
    logic [SIDE_W-1:0]    map_height;
    logic [TS_W-1:0]      tile_size;
    logic [PER_ROW_W-1:0] per_row;
  } tqvg_cfg_t;

  // map cell carried along the divider
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } tqvg_cell_t;

endpackage

`default_nettype wire

FILE: rtl/core/tqvg_cfg.sv
// configuration registers and the serial tiles-per-row divider
`default_nettype none

module tqvg_cfg (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [tqvg_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [tqvg_pkg::CFG_DATA_W-1:0]     cfg_data,
  output tqvg_pkg::tqvg_cfg_t                      cfg,
  output logic                                     busy
);

  logic [tqvg_pkg::SIDE_W-1:0]    map_width;
  logic [tqvg_pkg::SIDE_W-1:0]    map_height;
  logic [tqvg_pkg::TS_W-1:0]      tile_size;
  logic [tqvg_pkg::ATLAS_W-1:0]   atlas_width;
  logic [3:0]                     iter;
  logic [tqvg_pkg::TS_W-1:0]      rem;
  logic [tqvg_pkg::PER_ROW_W-1:0] quo;
  logic [tqvg_pkg::TS_W:0]        trial;
  logic                           write;

  assign cfg_ready = 1'b1;
  assign write     = cfg_valid && cfg_ready;
  assign busy      = (iter != 4'd0);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      map_width   <= '0;
      map_height  <= '0;
      tile_size   <= '0;
      atlas_width <= '0;
    end else if (write) begin
      case (cfg_index)
        tqvg_pkg::CFG_MAP_WIDTH:   map_width   <= cfg_data[tqvg_pkg::SIDE_W-1:0];
        tqvg_pkg::CFG_MAP_HEIGHT:  map_height  <= cfg_data[tqvg_pkg::SIDE_W-1:0];
        tqvg_pkg::CFG_TILE_SIZE:   tile_size   <= cfg_data[tqvg_pkg::TS_W-1:0];
        tqvg_pkg::CFG_ATLAS_WIDTH: atlas_width <= cfg_data[tqvg_pkg::ATLAS_W-1:0];
        default: ;
      endcase
    end
  end

  // restoring divide of atlas width by tile size, one quotient bit a cycle
  assign trial = {rem, quo[tqvg_pkg::PER_ROW_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      iter <= 4'd0;
      rem  <= '0;
      quo  <= '0;
    end else if (write) begin
      iter <= tqvg_pkg::CFG_DIV_ITERS;
      rem  <= '0;
      if (cfg_index == tqvg_pkg::CFG_ATLAS_WIDTH) begin
        quo <= cfg_data[tqvg_pkg::ATLAS_W-1:0];
      end else begin
        quo <= atlas_width;
      end
    end else if (busy) begin
      iter <= iter - 4'd1;
      if (trial >= {1'b0, tile_size}) begin
        rem <= tqvg_pkg::TS_W'(trial - {1'b0, tile_size});
        quo <= {quo[tqvg_pkg::PER_ROW_W-2:0], 1'b1};
      end else begin
        rem <= trial[tqvg_pkg::TS_W-1:0];
        quo <= {quo[tqvg_pkg::PER_ROW_W-2:0], 1'b0};
      end
    end
  end

  assign cfg.map_width  = map_width;
  assign cfg.map_height = map_height;
  assign cfg.tile_size  = tile_size;
  assign cfg.per_row    = quo;

endmodule

`default_nettype wire

FILE: rtl/core/tqvg_div_stage.sv
// one pipeline stage of the tile number divider, DIV_STEPS quotient bits per stage
`default_nettype none

module tqvg_div_stage #(
  parameter int QW = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [tqvg_pkg::REM_W-1:0]          in_rem,
  input  wire logic [QW-1:0]                       in_dq,
  input  wire tqvg_pkg::tqvg_cell_t                in_cell,
  input  wire logic [tqvg_pkg::PER_ROW_W-1:0]      divisor,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [tqvg_pkg::REM_W-1:0]               out_rem,
  output logic [QW-1:0]                            out_dq,
  output tqvg_pkg::tqvg_cell_t                     out_cell
);

  logic [tqvg_pkg::REM_W-1:0] rem_w;
  logic [QW-1:0]              dq_w;
  logic [tqvg_pkg::REM_W:0]   trial;

  assign in_ready = !out_valid || out_ready;

  // restoring steps: remainder and dividend/quotient shift together
  always_comb begin
    rem_w = in_rem;
    dq_w  = in_dq;
    trial = '0;
    for (int i = 0; i < tqvg_pkg::DIV_STEPS; i++) begin
      trial = {rem_w, dq_w[QW-1]};
      if (trial >= {1'b0, divisor}) begin
        rem_w = tqvg_pkg::REM_W'(trial - {1'b0, divisor});
        dq_w  = {dq_w[QW-2:0], 1'b1};
      end else begin
        rem_w = trial[tqvg_pkg::REM_W-1:0];
        dq_w  = {dq_w[QW-2:0], 1'b0};
      end
    end
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_rem  <= rem_w;
      out_dq   <= dq_w;
      out_cell <= in_cell;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/tqvg_expand.sv
// per-tile products and the four-corner output sequencer
`default_nettype none

module tqvg_expand #(
  parameter int QW = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [tqvg_pkg::REM_W-1:0]          in_rem,
  input  wire logic [QW-1:0]                       in_dq,
  input  wire tqvg_pkg::tqvg_cell_t                in_cell,
  input  wire logic [tqvg_pkg::TS_W-1:0]           tile_size,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [tqvg_pkg::CORNER_W-1:0]            corner,
  output logic [tqvg_pkg::POS_W-1:0]               pos_x,
  output logic [tqvg_pkg::POS_W-1:0]               pos_y,
  output logic [tqvg_pkg::TEX_U_W-1:0]             tex_u,
  output logic [tqvg_pkg::TEX_V_W-1:0]             tex_v,
  output logic                                     last_corner
);

  logic                                           item_v;
  logic [tqvg_pkg::CORNER_W-1:0]                  cnt;
  logic [tqvg_pkg::POS_W-1:0]                     bx;
  logic [tqvg_pkg::POS_W-1:0]                     by;
  logic [tqvg_pkg::TEX_U_W-1:0]                   bu;
  logic [tqvg_pkg::TEX_V_W-1:0]                   bv;
  logic [tqvg_pkg::COL_W+tqvg_pkg::TS_W-1:0]      prod_x;
  logic [tqvg_pkg::ROW_W+tqvg_pkg::TS_W-1:0]      prod_y;
  logic [tqvg_pkg::REM_W+tqvg_pkg::TS_W-1:0]      prod_u;
  logic [QW+tqvg_pkg::TS_W-1:0]                   prod_v;
  logic                                           out_adv;
  logic                                           last_load;

  // top-left corner of the quad and of the atlas cell
  assign prod_x = in_cell.col * tile_size;
  assign prod_y = in_cell.row * tile_size;
  assign prod_u = in_rem * tile_size;
  assign prod_v = in_dq * tile_size;

  // handshake
  assign out_adv   = !out_valid || !out_stall;
  assign last_load = item_v && out_adv && (cnt == tqvg_pkg::CORNER_LAST);
  assign in_ready  = !item_v || last_load;

  // item hold and corner counter
  always_ff @(posedge clk) begin
    if (rst) begin
      item_v    <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_adv) begin
        out_valid <= item_v;
      end
      if (in_ready) begin
        item_v <= in_valid;
        cnt    <= '0;
      end else if (item_v && out_adv) begin
        cnt <= cnt + 2'd1;
      end
    end
  end

  // base values of the held tile
  always_ff @(posedge clk) begin
    if (in_ready) begin
      bx <= tqvg_pkg::POS_W'(prod_x);
      by <= tqvg_pkg::POS_W'(prod_y);
      bu <= prod_u[tqvg_pkg::TEX_U_W-1:0];
      bv <= tqvg_pkg::TEX_V_W'(prod_v);
    end
  end

  // output word: step right for odd corners, down for the bottom pair
  always_ff @(posedge clk) begin
    if (out_adv) begin
      corner      <= cnt;
      pos_x       <= bx + (cnt[0] ? tqvg_pkg::POS_W'(tile_size) : '0);
      pos_y       <= by + (cnt[1] ? tqvg_pkg::POS_W'(tile_size) : '0);
      tex_u       <= bu + (cnt[0] ? tqvg_pkg::TEX_U_W'(tile_size) : '0);
      tex_v       <= bv + (cnt[1] ? tqvg_pkg::TEX_V_W'(tile_size) : '0);
      last_corner <= (cnt == tqvg_pkg::CORNER_LAST);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/tile_quad_vertex_generator_top.sv
// top level of the tile quad vertex generator
//
// Input channel (in_valid/in_stall) takes one map cell per word: tile_number,
// column and row. Output channel (out_valid/out_stall) gives the four corners
// of the cell's quad as four words, corner 0 to 3, last_corner set on the
// fourth. Cells outside the map, or any cell while tile size, map size or
// tiles per atlas row is zero, give no word.
// Path: an accepted cell passes the input register, the tile number divider
// stages (four quotient bits each), the product register and the output
// register to its first corner; the other corners follow it in order.
// The single output port carries one corner a cycle while out_stall is low;
// the pipeline takes a new cell every cycle, unless busy, until the corner
// sequencer is full.
// Configuration writes (cfg_valid/cfg_ready, always ready) restart the
// tiles-per-row divider, which holds in_stall high while it runs.
// Reset clears the configuration, divider state and valid flags to zero, so
// nothing is emitted until configured. While out_stall is high the output
// word holds and the pipeline fills, then in_stall rises; nothing is lost or repeated.
`default_nettype none

module tile_quad_vertex_generator_top #(
  parameter int MAX_MAP_SIDE    = 1024,
  parameter int TILE_INDEX_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [tqvg_pkg::TILE_W-1:0]         tile_number,
  input  wire logic [tqvg_pkg::COL_W-1:0]          column,
  input  wire logic [tqvg_pkg::ROW_W-1:0]          row,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [tqvg_pkg::CORNER_W-1:0]            corner,
  output logic [tqvg_pkg::POS_W-1:0]               pos_x,
  output logic [tqvg_pkg::POS_W-1:0]               pos_y,
  output logic [tqvg_pkg::TEX_U_W-1:0]             tex_u,
  output logic [tqvg_pkg::TEX_V_W-1:0]             tex_v,
  output logic                                     last_corner,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [tqvg_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [tqvg_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int TILE_BITS  = (TILE_INDEX_BITS < tqvg_pkg::TILE_W) ?
                              TILE_INDEX_BITS : tqvg_pkg::TILE_W;
  localparam int DIV_STAGES = (TILE_BITS + tqvg_pkg::DIV_STEPS - 1) / tqvg_pkg::DIV_STEPS;
  localparam int QW         = DIV_STAGES * tqvg_pkg::DIV_STEPS;
  localparam int SIDE_BITS  = $clog2(MAX_MAP_SIDE + 1);
  localparam int CMP_W      = (SIDE_BITS > tqvg_pkg::COL_W) ? SIDE_BITS : tqvg_pkg::COL_W;

  tqvg_pkg::tqvg_cfg_t        cfg;
  logic                       busy;
  logic                       dv_valid [DIV_STAGES+1];
  logic                       dv_ready [DIV_STAGES+2];
  logic [tqvg_pkg::REM_W-1:0] dv_rem   [DIV_STAGES+1];
  logic [QW-1:0]              dv_dq    [DIV_STAGES+1];
  tqvg_pkg::tqvg_cell_t       dv_cell  [DIV_STAGES+1];
  logic [TILE_BITS-1:0]       tile_eff;
  logic                       col_ok;
  logic                       row_ok;
  logic                       keep;

  // configuration
  tqvg_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .busy      (busy)
  );

  // cell filter: inside the clamped map and a usable configuration
  assign tile_eff = tile_number[TILE_BITS-1:0];
  assign col_ok   = ({1'b0, column} < cfg.map_width) &&
                    (CMP_W'(column) < CMP_W'(MAX_MAP_SIDE));
  assign row_ok   = ({1'b0, row} < cfg.map_height) &&
                    (CMP_W'(row) < CMP_W'(MAX_MAP_SIDE));
  assign keep     = col_ok && row_ok && (cfg.tile_size != '0) && (cfg.per_row != '0);

  assign dv_ready[0] = !dv_valid[0] || dv_ready[1];
  assign in_stall    = busy || !dv_ready[0];

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (dv_ready[0]) begin
      dv_valid[0] <= in_valid && !busy && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (dv_ready[0]) begin
      dv_rem[0]      <= '0;
      dv_dq[0]       <= QW'(tile_eff);
      dv_cell[0].col <= column;
      dv_cell[0].row <= row;
    end
  end

  // tile number divider: u is the remainder, v the quotient
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    tqvg_div_stage #(.QW(QW)) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dv_valid[s]),
      .in_ready  (dv_ready[s+1]),
      .in_rem    (dv_rem[s]),
      .in_dq     (dv_dq[s]),
      .in_cell   (dv_cell[s]),
      .divisor   (cfg.per_row),
      .out_valid (dv_valid[s+1]),
      .out_ready (dv_ready[s+2]),
      .out_rem   (dv_rem[s+1]),
      .out_dq    (dv_dq[s+1]),
      .out_cell  (dv_cell[s+1])
    );
  end

  // products and corner sequencing
  tqvg_expand #(.QW(QW)) u_expand (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (dv_valid[DIV_STAGES]),
    .in_ready    (dv_ready[DIV_STAGES+1]),
    .in_rem      (dv_rem[DIV_STAGES]),
    .in_dq       (dv_dq[DIV_STAGES]),
    .in_cell     (dv_cell[DIV_STAGES]),
    .tile_size   (cfg.tile_size),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .corner      (corner),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .tex_u       (tex_u),
    .tex_v       (tex_v),
    .last_corner (last_corner)
  );

endmodule

`default_nettype wire

FILE: rtl/core/tqvg_checker.sv
// port-level checks of the tile quad vertex generator and their binding
`default_nettype none

module tqvg_checker (
  input wire logic                                 clk,
  input wire logic                                 rst,
  input wire logic                                 out_valid,
  input wire logic                                 out_stall,
  input wire logic [tqvg_pkg::CORNER_W-1:0]        corner,
  input wire logic [tqvg_pkg::POS_W-1:0]           pos_x,
  input wire logic [tqvg_pkg::POS_W-1:0]           pos_y,
  input wire logic                                 last_corner
);

  // no word right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // a stalled word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(corner) && $stable(pos_x) &&
                               $stable(pos_y))
    else $error("stalled output word changed");

  // the corners of one quad come back to back in order
  a_corner_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_corner |=>
      out_valid && (corner == $past(corner) + 2'd1))
    else $error("corner sequence broken");

  // top-right shares the row of top-left
  a_top_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && (corner == 2'd0) |=> pos_y == $past(pos_y))
    else $error("top corners differ in y");

endmodule

bind tile_quad_vertex_generator_top tqvg_checker u_checker (.*);

`default_nettype wire
